@@ hdl/qlsp_pkg.sv @@
// Package for the quality level switch policy block.
// Holds the beat structs, configuration view, register indexes and verdict codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qlsp_pkg;

  // Field widths fixed by the packet format.
  localparam int LVL_W     = 2;
  localparam int HDR_W     = 32;
  localparam int AGE_W     = 24;
  localparam int CHUNK_W   = 16;
  localparam int PRES_W    = 3;
  localparam int LIMIT_W   = 8;
  localparam int LDROP_W   = 16;
  localparam int TDROP_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 24;

  // Chunk value that marks the tracked chunk as not yet loaded.
  localparam logic [CHUNK_W-1:0] UNSET_CHUNK = 16'hFFFF;

  // Register reset values.
  localparam logic [LVL_W-1:0]   RST_START_LEVEL    = 2'd0;
  localparam logic [PRES_W-1:0]  RST_LEVELS_PRESENT = 3'd7;
  localparam logic [LIMIT_W-1:0] RST_DROP_LIMIT     = 8'd3;
  localparam logic [AGE_W-1:0]   RST_LATE_LIMIT_US  = 24'd10000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LEVEL    = 2'd0,
    REG_LEVELS_PRESENT = 2'd1,
    REG_DROP_LIMIT     = 2'd2,
    REG_LATE_LIMIT_US  = 2'd3
  } cfg_reg_t;

  // Verdict codes.
  typedef enum logic [1:0] {
    VERDICT_DROP  = 2'd0,
    VERDICT_USE   = 2'd1,
    VERDICT_SAVE  = 2'd2,
    VERDICT_FAULT = 2'd3
  } verdict_t;

  // One received packet.
  typedef struct packed {
    logic [LVL_W-1:0] arrival_level;
    logic [HDR_W-1:0] header_word;
    logic             first_packet;
    logic [AGE_W-1:0] age_us;
  } in_item_t;

  // One policy decision.
  typedef struct packed {
    logic [1:0]         verdict;
    logic [CHUNK_W-1:0] packet_chunk;
    logic               join_valid;
    logic [LVL_W-1:0]   join_level;
    logic               leave_valid;
    logic               finish_lookaside;
    logic [LVL_W-1:0]   level_now;
    logic [LDROP_W-1:0] drops_at_level;
    logic [TDROP_W-1:0] drops_total;
  } out_item_t;

  // Configuration as seen by the policy logic.
  typedef struct packed {
    logic               start_load;
    logic [LVL_W-1:0]   start_value;
    logic [PRES_W-1:0]  levels_present;
    logic [LIMIT_W-1:0] drop_limit;
    logic [AGE_W-1:0]   late_limit_us;
  } cfg_t;

endpackage

`default_nettype wire

@@ hdl/qlsp_cfg_regs.sv @@
// Configuration register file for the quality level switch policy.
// Depends on qlsp_pkg for widths, register indexes and the cfg_t view.
`timescale 1ns / 1ps
`default_nettype none

module qlsp_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [qlsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [qlsp_pkg::CFG_DW-1:0]  cfg_wdata,
  output qlsp_pkg::cfg_t                    cfg
);

  logic [qlsp_pkg::PRES_W-1:0]  levels_present_r;
  logic [qlsp_pkg::LIMIT_W-1:0] drop_limit_r;
  logic [qlsp_pkg::AGE_W-1:0]   late_limit_r;
  logic                         start_hit;

  assign start_hit = cfg_we && (cfg_index == qlsp_pkg::REG_START_LEVEL);

  // Register writes; the start level goes straight to the policy state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_present_r <= qlsp_pkg::RST_LEVELS_PRESENT;
      drop_limit_r     <= qlsp_pkg::RST_DROP_LIMIT;
      late_limit_r     <= qlsp_pkg::RST_LATE_LIMIT_US;
    end else if (cfg_we) begin
      case (cfg_index)
        qlsp_pkg::REG_LEVELS_PRESENT: levels_present_r <= cfg_wdata[qlsp_pkg::PRES_W-1:0];
        qlsp_pkg::REG_DROP_LIMIT:     drop_limit_r     <= cfg_wdata[qlsp_pkg::LIMIT_W-1:0];
        qlsp_pkg::REG_LATE_LIMIT_US:  late_limit_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Present the configuration as one struct.
  always_comb begin
    cfg.start_load     = start_hit;
    cfg.start_value    = cfg_wdata[qlsp_pkg::LVL_W-1:0];
    cfg.levels_present = levels_present_r;
    cfg.drop_limit     = drop_limit_r;
    cfg.late_limit_us  = late_limit_r;
  end

endmodule

`default_nettype wire

@@ hdl/qlsp_stage.sv @@
// One valid/ready register stage carrying a packed payload.
// Used for the input register and the result register; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module qlsp_stage #(
  parameter type DATA_T = logic
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  s_valid,
  output logic       s_ready,
  input  wire DATA_T s_data,
  output logic       m_valid,
  input  wire logic  m_ready,
  output DATA_T      m_data
);

  logic  valid_r;
  DATA_T data_r;

  // The stage takes a beat when empty or when its beat leaves this cycle.
  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      data_r <= s_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/qlsp_policy.sv @@
// Level switch policy state and single-pass decision logic.
// Depends on qlsp_pkg for the beat structs, cfg_t and verdict codes.
`timescale 1ns / 1ps
`default_nettype none

module qlsp_policy #(
  parameter int LEVEL_COUNT = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire qlsp_pkg::cfg_t     cfg,
  input  wire logic               fire,
  input  wire qlsp_pkg::in_item_t item,
  output qlsp_pkg::out_item_t     res
);

  localparam int LW = qlsp_pkg::LVL_W;
  localparam int CW = qlsp_pkg::CHUNK_W;
  localparam int DW = qlsp_pkg::LDROP_W;
  localparam int TW = qlsp_pkg::TDROP_W;

  // Policy state.
  logic [CW-1:0]          tracked_chunk_r, tracked_chunk_nxt;
  logic [LW-1:0]          control_level_r, control_level_nxt;
  logic [LW-1:0]          current_level_r, current_level_nxt;
  logic [LW-1:0]          pending_level_r, pending_level_nxt;
  logic                   pending_valid_r, pending_valid_nxt;
  logic [DW-1:0]          level_drops_r, level_drops_nxt;
  logic [TW-1:0]          total_drops_r, total_drops_nxt;
  logic [LEVEL_COUNT-1:0] moving_r, moving_nxt;
  logic [LEVEL_COUNT-1:0] just_moved_r, just_moved_nxt;

  // Working values.
  logic [LEVEL_COUNT-1:0] arr_hot, pend_hot;
  logic [CW-1:0]          chunk, tc_eff;
  logic [LW-1:0]          arr;
  logic                   loss, moving_arr, just_moved_arr, down, at_edge, tgt_exists;
  logic [LW:0]            target;
  logic [qlsp_pkg::PRES_W:0] present_ext;
  logic [DW-1:0]          ldrops_inc;
  logic [TW-1:0]          tdrops_inc;

  assign arr   = item.arrival_level;
  assign chunk = item.header_word[qlsp_pkg::HDR_W-1 -: CW];

  // One-hot selects into the per-level flags; levels past the count select nothing.
  for (genvar i = 0; i < LEVEL_COUNT; i++) begin : g_hot
    assign arr_hot[i]  = (int'(arr) == i);
    assign pend_hot[i] = (int'(pending_level_r) == i);
  end

  assign moving_arr     = |(moving_r & arr_hot);
  assign just_moved_arr = |(just_moved_r & arr_hot);

  // Loss counting with saturation.
  assign loss = item.first_packet || (item.age_us > cfg.late_limit_us);
  assign ldrops_inc = (loss && (level_drops_r != '1)) ? level_drops_r + 1'b1 : level_drops_r;
  assign tdrops_inc = (loss && (total_drops_r != '1)) ? total_drops_r + 1'b1 : total_drops_r;

  // An unset tracked chunk is loaded from the packet.
  assign tc_eff = (tracked_chunk_r == qlsp_pkg::UNSET_CHUNK) ? chunk : tracked_chunk_r;

  // Step direction and the level it would move to.
  assign down    = ({{(DW - qlsp_pkg::LIMIT_W){1'b0}}, cfg.drop_limit} <= ldrops_inc);
  assign at_edge = down ? (current_level_r == '0) : (int'(current_level_r) + 1 == LEVEL_COUNT);
  assign target  = down ? ({1'b0, current_level_r} - 1'b1) : ({1'b0, current_level_r} + 1'b1);
  assign present_ext = {1'b0, cfg.levels_present};
  assign tgt_exists  = (int'(target) < LEVEL_COUNT) && (target < (LW + 1)'(qlsp_pkg::PRES_W))
                       && present_ext[target[LW-1:0]];

  // Decision for the packet in the input register.
  always_comb begin
    tracked_chunk_nxt = tc_eff;
    control_level_nxt = control_level_r;
    current_level_nxt = current_level_r;
    pending_level_nxt = pending_level_r;
    pending_valid_nxt = pending_valid_r;
    level_drops_nxt   = ldrops_inc;
    total_drops_nxt   = tdrops_inc;
    moving_nxt        = moving_r;
    just_moved_nxt    = just_moved_r;

    res.verdict          = qlsp_pkg::VERDICT_DROP;
    res.packet_chunk     = chunk;
    res.join_valid       = 1'b0;
    res.join_level       = '0;
    res.leave_valid      = 1'b0;
    res.finish_lookaside = 1'b0;

    if (control_level_r != arr) begin
      // Another level's packet: keep it for look-aside when it is ahead.
      res.verdict = (chunk > tc_eff) ? qlsp_pkg::VERDICT_SAVE : qlsp_pkg::VERDICT_DROP;
    end else if (moving_arr) begin
      // The old level's next packet completes the switch.
      moving_nxt = moving_r & ~arr_hot;
      if (pending_valid_r) begin
        control_level_nxt    = pending_level_r;
        current_level_nxt    = pending_level_r;
        pending_valid_nxt    = 1'b0;
        pending_level_nxt    = '0;
        level_drops_nxt      = '0;
        just_moved_nxt       = just_moved_r | pend_hot;
        res.finish_lookaside = 1'b1;
        res.leave_valid      = 1'b1;
      end
    end else if (chunk < tc_eff) begin
      res.verdict = qlsp_pkg::VERDICT_DROP;
    end else if (chunk == tc_eff) begin
      res.verdict = qlsp_pkg::VERDICT_USE;
    end else begin
      // New chunk on the control level.
      tracked_chunk_nxt = chunk;
      if (just_moved_arr) begin
        just_moved_nxt = just_moved_r & ~arr_hot;
        res.verdict    = qlsp_pkg::VERDICT_USE;
      end else if (at_edge) begin
        level_drops_nxt = '0;
        res.verdict     = qlsp_pkg::VERDICT_USE;
      end else if (tgt_exists) begin
        pending_level_nxt = target[LW-1:0];
        pending_valid_nxt = 1'b1;
        moving_nxt        = moving_r | arr_hot;
        res.join_valid    = 1'b1;
        res.join_level    = target[LW-1:0];
        res.verdict       = qlsp_pkg::VERDICT_USE;
      end else begin
        pending_valid_nxt = 1'b0;
        pending_level_nxt = '0;
        res.verdict       = qlsp_pkg::VERDICT_FAULT;
      end
    end

    res.level_now      = current_level_nxt;
    res.drops_at_level = level_drops_nxt;
    res.drops_total    = total_drops_nxt;
  end

  // State registers; a start level write reloads the levels in control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_chunk_r <= qlsp_pkg::UNSET_CHUNK;
      control_level_r <= qlsp_pkg::RST_START_LEVEL;
      current_level_r <= qlsp_pkg::RST_START_LEVEL;
      pending_level_r <= '0;
      pending_valid_r <= 1'b0;
      level_drops_r   <= '0;
      total_drops_r   <= '0;
      moving_r        <= '0;
      just_moved_r    <= '0;
    end else if (cfg.start_load) begin
      control_level_r <= cfg.start_value;
      current_level_r <= cfg.start_value;
    end else if (fire) begin
      tracked_chunk_r <= tracked_chunk_nxt;
      control_level_r <= control_level_nxt;
      current_level_r <= current_level_nxt;
      pending_level_r <= pending_level_nxt;
      pending_valid_r <= pending_valid_nxt;
      level_drops_r   <= level_drops_nxt;
      total_drops_r   <= total_drops_nxt;
      moving_r        <= moving_nxt;
      just_moved_r    <= just_moved_nxt;
    end
  end

  // The control and current levels always move together.
  a_levels_agree: assert property (@(posedge clk) disable iff (!rst_n)
    control_level_r == current_level_r)
    else $error("control and current level differ");

  // A requested join leaves a pending switch behind.
  a_join_pends: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.join_valid && !cfg.start_load) |=> pending_valid_r)
    else $error("join issued without a pending switch");

  // A completed switch consumes the pending target.
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.finish_lookaside && !cfg.start_load) |=> !pending_valid_r)
    else $error("pending switch survived its completion");

  // The total loss count never goes backward.
  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> total_drops_r >= $past(total_drops_r))
    else $error("total loss count decreased");

endmodule

`default_nettype wire

@@ hdl/quality_level_switch_policy_top.sv @@
// A packet beat passes through the input register, the decision pass and then the
// result register. Throughput: one packet per cycle while out_ready is high,
// set by the single decision pass between the two registers.
// Reset (rst_n, synchronous, active low) empties both registers, loads the
// register defaults, sets the tracked chunk to unset and clears all counters.
// Depends on qlsp_pkg, qlsp_cfg_regs, qlsp_stage and qlsp_policy.
`timescale 1ns / 1ps
`default_nettype none

module quality_level_switch_policy_top #(
  parameter int LEVEL_COUNT = 3
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire qlsp_pkg::in_item_t             in_item,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output qlsp_pkg::out_item_t                 out_item,
  input  wire logic                           cfg_we,
  input  wire logic [qlsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [qlsp_pkg::CFG_DW-1:0]    cfg_wdata
);

  qlsp_pkg::cfg_t      cfg;
  qlsp_pkg::in_item_t  item;
  qlsp_pkg::out_item_t res;
  logic                item_valid;
  logic                res_ready;
  logic                fire;

  // A decision is made when the input register holds a beat the result register can take.
  assign fire = item_valid && res_ready;

  qlsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  qlsp_stage #(.DATA_T(qlsp_pkg::in_item_t)) u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .s_data  (in_item),
    .m_valid (item_valid),
    .m_ready (res_ready),
    .m_data  (item)
  );

  qlsp_policy #(.LEVEL_COUNT(LEVEL_COUNT)) u_policy (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  qlsp_stage #(.DATA_T(qlsp_pkg::out_item_t)) u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (item_valid),
    .s_ready (res_ready),
    .s_data  (res),
    .m_valid (out_valid),
    .m_ready (out_ready),
    .m_data  (out_item)
  );

endmodule

`default_nettype wire
